// File: src/pulse_baseline_min_window_charge_assert.svh
// Assertion macros shared by the pulse charge block.
// Modules that use them must have a signal named clock and a signal named reset.
`ifndef PULSE_BASELINE_MIN_WINDOW_CHARGE_ASSERT_SVH
`define PULSE_BASELINE_MIN_WINDOW_CHARGE_ASSERT_SVH

// Checked on every clock edge outside reset.
`define PBMWC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define PBMWC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: src/pbmwc_pkg.sv
// Package for the pulse charge block: widths, constants, register indexes and
// the transaction types shared by all modules. No dependencies.
package pbmwc_pkg;

   localparam int unsigned MAX_WORDS      = 4096;
   localparam int unsigned WORD_COUNT_W   = $clog2(MAX_WORDS + 1);
   localparam int unsigned INDEX_W        = $clog2(MAX_WORDS);

   localparam int unsigned SAMPLE_W       = 16;
   localparam int unsigned PAIR_SUM_W     = SAMPLE_W + 1;
   localparam int unsigned LOWEST_W       = SAMPLE_W + 1;
   localparam int unsigned BASELINE_W     = 20;
   localparam int unsigned WINDOW_W       = 20;
   localparam int unsigned CHARGE_W       = 24;
   localparam int unsigned CHARGE_EXT_W   = CHARGE_W + 1;
   localparam int unsigned MIN_INDEX_FIELD_W = 12;
   localparam int unsigned ID_W           = 8;
   localparam int unsigned CFG_W          = 9;
   localparam int unsigned CSR_INDEX_W    = 1;

   localparam int unsigned BASELINE_WORDS = 5;
   localparam int unsigned FIRST_INDEX    = 3;
   localparam int unsigned TAIL_WORDS     = 3;
   localparam int signed   LARGE_LIMIT    = 300000;

   localparam logic [LOWEST_W-1:0] LOWEST_RESET = LOWEST_W'(17'h10000);
   localparam logic [CFG_W-1:0]    SELECT_ANY   = '1;

   localparam logic [CSR_INDEX_W-1:0] REG_SELECT_CHANNEL = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_SELECT_MODULE  = CSR_INDEX_W'(1);

   typedef struct packed {
      logic [31:0]      sample_pair;
      logic             last_word;
      logic [ID_W-1:0]  source_channel;
      logic [ID_W-1:0]  source_module;
   } req_payload_type;

   typedef struct packed {
      logic signed [CHARGE_W-1:0]   charge_tenths;
      logic                         large_pulse;
      logic [MIN_INDEX_FIELD_W-1:0] min_word_index;
      logic [SAMPLE_W-1:0]          min_sample;
   } rsp_payload_type;

   typedef struct packed {
      logic                  valid;
      logic [SAMPLE_W-1:0]   sample_lo;
      logic [SAMPLE_W-1:0]   sample_hi;
      logic [PAIR_SUM_W-1:0] pair_sum;
      logic                  last_word;
      logic [ID_W-1:0]       source_channel;
      logic [ID_W-1:0]       source_module;
   } item_type;

   typedef struct packed {
      logic            emit;
      rsp_payload_type payload;
   } track_result_type;

endpackage

// File: src/pbmwc_in_stage.sv
// Input register of the pulse charge block: captures a request transaction
// and splits the word into its two samples and their sum. Uses pbmwc_pkg.
module pbmwc_in_stage
   import pbmwc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   input  logic            take,
   output item_type        item
);

   item_type item_ff;
   item_type item_in;
   logic     load;

   assign req_stall = item_ff.valid & ~take;
   assign load      = ~item_ff.valid | take;

   always_comb begin
      item_in                = item_ff;
      item_in.valid          = req_valid;
      item_in.sample_lo      = req_payload.sample_pair[SAMPLE_W-1:0];
      item_in.sample_hi      = req_payload.sample_pair[2*SAMPLE_W-1:SAMPLE_W];
      item_in.pair_sum       = PAIR_SUM_W'(req_payload.sample_pair[SAMPLE_W-1:0])
                             + PAIR_SUM_W'(req_payload.sample_pair[2*SAMPLE_W-1:SAMPLE_W]);
      item_in.last_word      = req_payload.last_word;
      item_in.source_channel = req_payload.source_channel;
      item_in.source_module  = req_payload.source_module;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else if (load) begin
         item_ff.valid <= item_in.valid;
      end
      if (load && req_valid) begin
         item_ff.sample_lo      <= item_in.sample_lo;
         item_ff.sample_hi      <= item_in.sample_hi;
         item_ff.pair_sum       <= item_in.pair_sum;
         item_ff.last_word      <= item_in.last_word;
         item_ff.source_channel <= item_in.source_channel;
         item_ff.source_module  <= item_in.source_module;
      end
   end

   assign item = item_ff;

endmodule

// File: src/pbmwc_tracker.sv
// Waveform tracker: filter registers, running baseline, lowest sample search,
// window sum and the charge result of a waveform. Uses pbmwc_pkg and the
// assertion macro header.
`include "pulse_baseline_min_window_charge_assert.svh"

module pbmwc_tracker
   import pbmwc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_write_data,
   input  item_type               item,
   input  logic                   step,
   output track_result_type       result
);

   logic [CFG_W-1:0]        select_channel_ff;
   logic [CFG_W-1:0]        select_module_ff;

   logic [WORD_COUNT_W-1:0] word_count_ff,      word_count_in;
   logic [BASELINE_W-1:0]   baseline_sum_ff,    baseline_sum_in;
   logic [LOWEST_W-1:0]     lowest_value_ff,    lowest_value_in;
   logic [INDEX_W-1:0]      lowest_index_ff,    lowest_index_in;
   logic [PAIR_SUM_W-1:0]   pair_sum0_ff,       pair_sum0_in;
   logic [PAIR_SUM_W-1:0]   pair_sum1_ff,       pair_sum1_in;
   logic [WINDOW_W-1:0]     window_partial_ff,  window_partial_in;
   logic                    window_pending_ff,  window_pending_in;
   logic                    filter_pass_ff,     filter_pass_in;

   logic                    channel_match;
   logic                    module_match;
   logic                    filter_now;
   logic                    active;
   logic [SAMPLE_W-1:0]     pair_min;
   logic                    new_min;
   logic                    in_bounds;
   logic [CHARGE_W-1:0]     baseline_x12;
   logic [CHARGE_W-1:0]     window_x10;
   logic signed [CHARGE_EXT_W-1:0] charge_wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         select_channel_ff <= SELECT_ANY;
         select_module_ff  <= SELECT_ANY;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_SELECT_CHANNEL: select_channel_ff <= csr_write_data;
            REG_SELECT_MODULE:  select_module_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign channel_match = ~select_channel_ff[CFG_W-1]
                        & (select_channel_ff[ID_W-1:0] == item.source_channel);
   assign module_match  = ~select_module_ff[CFG_W-1]
                        & (select_module_ff[ID_W-1:0] == item.source_module);

   always_comb begin
      if (select_channel_ff == SELECT_ANY) begin
         filter_now = 1'b1;
      end else if (select_module_ff == SELECT_ANY) begin
         filter_now = channel_match;
      end else begin
         filter_now = channel_match | module_match;
      end
   end

   assign active   = word_count_ff < WORD_COUNT_W'(MAX_WORDS);
   assign pair_min = (item.sample_hi < item.sample_lo) ? item.sample_hi : item.sample_lo;
   assign new_min  = LOWEST_W'(pair_min) < lowest_value_ff;

   always_comb begin
      word_count_in     = word_count_ff;
      baseline_sum_in   = baseline_sum_ff;
      lowest_value_in   = lowest_value_ff;
      lowest_index_in   = lowest_index_ff;
      pair_sum0_in      = pair_sum0_ff;
      pair_sum1_in      = pair_sum1_ff;
      window_partial_in = window_partial_ff;
      window_pending_in = window_pending_ff;
      filter_pass_in    = (word_count_ff == '0) ? filter_now : filter_pass_ff;
      if (active) begin
         if (window_pending_ff) begin
            window_partial_in = window_partial_ff + WINDOW_W'(item.pair_sum);
            window_pending_in = 1'b0;
         end
         if (word_count_ff < WORD_COUNT_W'(BASELINE_WORDS)) begin
            baseline_sum_in = baseline_sum_ff + BASELINE_W'(item.pair_sum);
         end
         if (new_min) begin
            lowest_value_in   = LOWEST_W'(pair_min);
            lowest_index_in   = word_count_ff[INDEX_W-1:0];
            window_partial_in = WINDOW_W'(pair_sum1_ff)
                              + (WINDOW_W'(pair_sum0_ff) << 1)
                              + (WINDOW_W'(item.pair_sum) << 1);
            window_pending_in = 1'b1;
         end
         pair_sum1_in  = pair_sum0_ff;
         pair_sum0_in  = item.pair_sum;
         word_count_in = word_count_ff + WORD_COUNT_W'(1);
      end
   end

   assign in_bounds = (lowest_index_in >= INDEX_W'(FIRST_INDEX))
                    & ((WORD_COUNT_W'(lowest_index_in) + WORD_COUNT_W'(TAIL_WORDS))
                       <= word_count_in);

   assign baseline_x12 = (CHARGE_W'(baseline_sum_in) << 3) + (CHARGE_W'(baseline_sum_in) << 2);
   assign window_x10   = (CHARGE_W'(window_partial_in) << 3)
                       + (CHARGE_W'(window_partial_in) << 1);
   assign charge_wide  = $signed({1'b0, baseline_x12}) - $signed({1'b0, window_x10});

   always_comb begin
      result.emit                   = item.valid & item.last_word & filter_pass_in
                                    & in_bounds & ~window_pending_in;
      result.payload.charge_tenths  = charge_wide[CHARGE_W-1:0];
      result.payload.large_pulse    = charge_wide > CHARGE_EXT_W'(LARGE_LIMIT);
      result.payload.min_word_index = MIN_INDEX_FIELD_W'(lowest_index_in);
      result.payload.min_sample     = lowest_value_in[SAMPLE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset || (step && item.last_word)) begin
         word_count_ff     <= '0;
         baseline_sum_ff   <= '0;
         lowest_value_ff   <= LOWEST_RESET;
         lowest_index_ff   <= '0;
         pair_sum0_ff      <= '0;
         pair_sum1_ff      <= '0;
         window_partial_ff <= '0;
         window_pending_ff <= 1'b0;
         filter_pass_ff    <= 1'b1;
      end else if (step) begin
         word_count_ff     <= word_count_in;
         baseline_sum_ff   <= baseline_sum_in;
         lowest_value_ff   <= lowest_value_in;
         lowest_index_ff   <= lowest_index_in;
         pair_sum0_ff      <= pair_sum0_in;
         pair_sum1_ff      <= pair_sum1_in;
         window_partial_ff <= window_partial_in;
         window_pending_ff <= window_pending_in;
         filter_pass_ff    <= filter_pass_in;
      end
   end

   `PBMWC_ASSERT_ALWAYS(a_reset_clears_count, reset |=> (word_count_ff == '0), "word count not cleared by reset")
   `PBMWC_ASSERT(a_pending_is_previous_word, window_pending_ff |-> ((WORD_COUNT_W'(lowest_index_ff) + WORD_COUNT_W'(1)) == word_count_ff), "pending window does not belong to the previous word")
   `PBMWC_ASSERT(a_last_clears_waveform, (step && item.last_word) |=> ((word_count_ff == '0) && !window_pending_ff && (lowest_value_ff == LOWEST_RESET)), "waveform state not cleared after the last word")

endmodule

// File: src/pulse_baseline_min_window_charge.sv
// Pulse charge from the lowest sample of a digitizer waveform.
// Request channel (req_): one transaction per 32-bit word holding two 16-bit samples,
// low half first; last_word ends the waveform; channel and module tag the waveform.
// Result channel (rsp_): at most one transaction per waveform, issued for its last word
// when the waveform passes the channel/module filter and the lowest sample lies at
// least three words from the start and is followed by at least two more words.
// Configuration port (csr_): index 0 selects the channel (-1 accepts all), index 1 the
// module; writes take effect at the clock edge; the user must make them only while the
// block is idle, which the block itself does not enforce. Throughput: one word per
// cycle, unless a held result blocks a word that would produce another. Each word
// passes an input register and, when the tracker steps it, one pass of tracker logic
// into the result register. Reset (synchronous, active high) clears all waveform
// state, the valid bits of both transaction registers, and sets both selects to -1.
// While rsp_stall holds a result, words that produce no result keep flowing; a word
// that would produce a result waits in the input register, and req_stall rises behind it.
// Uses pbmwc_pkg, pbmwc_in_stage, pbmwc_tracker and the assertion macro header.
`include "pulse_baseline_min_window_charge_assert.svh"

module pulse_baseline_min_window_charge
   import pbmwc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_payload_type        req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_payload,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_write_data
);

   item_type         item;
   track_result_type result;
   logic             step;
   logic             rsp_valid_ff;
   rsp_payload_type  rsp_payload_ff;

   pbmwc_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .take        (step),
      .item        (item)
   );

   pbmwc_tracker u_tracker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .item             (item),
      .step             (step),
      .result           (result)
   );

   assign step = item.valid & (~result.emit | ~rsp_valid_ff | ~rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step && result.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (step && result.emit) begin
         rsp_payload_ff <= result.payload;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `PBMWC_ASSERT(a_result_registered, (step && result.emit) |=> (rsp_valid && (rsp_payload == $past(result.payload))), "result transaction not captured")

endmodule
